@@ sv/clt_pkg.sv @@
// Shared types and constants for the character LCD cursor terminal.
// Used by the front, queue, back and top-level modules; no dependencies.
package clt_pkg;

  localparam int MAX_ROWS = 4;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [6:0] CH_LF        = 7'd10;
  localparam logic [6:0] CH_CR        = 7'd13;
  localparam logic [6:0] CH_MIN       = 7'd10;

  localparam logic [5:0] COLS_RESET  = 6'd16;
  localparam logic [2:0] ROWS_RESET  = 3'd2;
  localparam logic [6:0] BASE0_RESET = 7'd0;
  localparam logic [6:0] BASE1_RESET = 7'd64;
  localparam logic [6:0] BASE2_RESET = 7'd16;
  localparam logic [6:0] BASE3_RESET = 7'd80;

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_SETXY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_COLUMNS = 3'd0,
    CFG_ROWS    = 3'd1,
    CFG_BASE0   = 3'd2,
    CFG_BASE1   = 3'd3,
    CFG_BASE2   = 3'd4,
    CFG_BASE3   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [7:0] char_code;
    logic [6:0]        x_pos;
    logic [2:0]        y_pos;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One controller byte before it gets its last flag.
  typedef struct packed {
    logic       is_data;
    logic [7:0] data;
  } lcd_byte_t;

  // Work for the back end: one or two bytes caused by one request.
  typedef struct packed {
    logic      two;
    lcd_byte_t b0;
    lcd_byte_t b1;
  } op_t;

endpackage

@@ sv/clt_front.sv @@
// Front end: holds configuration and cursor, turns each request into at most one op.
// Depends on clt_pkg.
module clt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  clt_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output logic              op_push,
  output clt_pkg::op_t      op
);

  logic [5:0] cols_r;
  logic [2:0] rows_r;
  logic [6:0] base_r [4];
  logic [2:0] row_r, row_nxt;
  logic [6:0] col_r, col_nxt;

  logic [3:0] next_row;
  logic       next_fits;
  logic       is_setxy;
  logic       is_cr;
  logic [2:0] pos_row;
  logic [6:0] pos_col;
  logic       pos_ok;
  logic [7:0] pos_byte;
  logic       ignored;
  logic       any;
  clt_pkg::lcd_byte_t ch_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= clt_pkg::COLS_RESET;
      rows_r    <= clt_pkg::ROWS_RESET;
      base_r[0] <= clt_pkg::BASE0_RESET;
      base_r[1] <= clt_pkg::BASE1_RESET;
      base_r[2] <= clt_pkg::BASE2_RESET;
      base_r[3] <= clt_pkg::BASE3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        clt_pkg::CFG_COLUMNS: cols_r    <= cfg_data[5:0];
        clt_pkg::CFG_ROWS:    rows_r    <= cfg_data[2:0];
        clt_pkg::CFG_BASE0:   base_r[0] <= cfg_data;
        clt_pkg::CFG_BASE1:   base_r[1] <= cfg_data;
        clt_pkg::CFG_BASE2:   base_r[2] <= cfg_data;
        clt_pkg::CFG_BASE3:   base_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    next_row  = {1'b0, row_r} + 4'd1;
    next_fits = next_row < {1'b0, rows_r};
    is_setxy  = item.req_type == clt_pkg::REQ_SETXY;
    is_cr     = item.char_code[6:0] == clt_pkg::CH_CR;
    // The only position commands are: explicit set, CR on this row, or the
    // start of the next row (LF and wrap).
    pos_row   = is_setxy ? item.y_pos : (is_cr ? row_r : next_row[2:0]);
    pos_col   = is_setxy ? item.x_pos : 7'd0;
    pos_ok    = (pos_row < rows_r) && ({1'b0, pos_row} < 4'(clt_pkg::MAX_ROWS));
    pos_byte  = clt_pkg::CMD_SET_ADDR + {1'b0, base_r[pos_row[1:0]]} + {1'b0, pos_col};
    ignored   = item.char_code[7] || (item.char_code[6:0] < clt_pkg::CH_MIN);
    ch_byte   = '{is_data: 1'b1, data: 8'(item.char_code)};

    any     = 1'b0;
    op      = '0;
    row_nxt = row_r;
    col_nxt = col_r;

    case (item.req_type)
      clt_pkg::REQ_SETXY: begin
        row_nxt = item.y_pos;
        col_nxt = item.x_pos;
        any     = pos_ok;
        op.b0   = '{is_data: 1'b0, data: pos_byte};
      end
      clt_pkg::REQ_CLEAR: begin
        any     = 1'b1;
        op.two  = 1'b1;
        op.b0   = '{is_data: 1'b0, data: clt_pkg::CMD_CLEAR};
        op.b1   = '{is_data: 1'b0, data: clt_pkg::CMD_HOME};
        row_nxt = '0;
        col_nxt = '0;
      end
      clt_pkg::REQ_CHAR: begin
        if (ignored) begin
          any = 1'b0;
        end else if (is_cr) begin
          col_nxt = '0;
          any     = pos_ok;
          op.b0   = '{is_data: 1'b0, data: pos_byte};
        end else if (item.char_code[6:0] == clt_pkg::CH_LF || col_r >= {1'b0, cols_r}) begin
          // LF, or a printable character past the right edge.
          if (next_fits) begin
            row_nxt = next_row[2:0];
            if (item.char_code[6:0] == clt_pkg::CH_LF) begin
              col_nxt = '0;
              any     = pos_ok;
              op.b0   = '{is_data: 1'b0, data: pos_byte};
            end else begin
              col_nxt = 7'd1;
              any     = 1'b1;
              op.two  = pos_ok;
              op.b0   = pos_ok ? '{is_data: 1'b0, data: pos_byte} : ch_byte;
              op.b1   = ch_byte;
            end
          end else begin
            any     = 1'b1;
            op.two  = 1'b1;
            op.b0   = '{is_data: 1'b0, data: clt_pkg::CMD_CLEAR};
            op.b1   = '{is_data: 1'b0, data: clt_pkg::CMD_HOME};
            row_nxt = '0;
            col_nxt = '0;
          end
        end else begin
          any     = 1'b1;
          op.b0   = ch_byte;
          col_nxt = col_r + 7'd1;
        end
      end
      default: any = 1'b0;
    endcase

    op_push = accept && any;
  end

endmodule

@@ sv/clt_queue.sv @@
// Short queue of ops between the front end and the back end.
// Depends on clt_pkg.
module clt_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  clt_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output clt_pkg::op_t head
);

  clt_pkg::op_t mem [clt_pkg::QDEPTH];
  logic [clt_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [clt_pkg::QAW:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (clt_pkg::QAW+1)'(push) - (clt_pkg::QAW+1)'(pop);
    end
  end

  assign full  = count_r == (clt_pkg::QAW+1)'(clt_pkg::QDEPTH);
  assign valid = count_r != '0;
  assign head  = mem[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == (clt_pkg::QAW+1)'(clt_pkg::QDEPTH) |-> !push || pop)
    else $error("op queue pushed while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (clt_pkg::QAW+1)'(clt_pkg::QDEPTH))
    else $error("op queue count beyond depth");

endmodule

@@ sv/clt_back.sv @@
// Back end: steps through the bytes of each op into the output register.
// Depends on clt_pkg.
module clt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  clt_pkg::op_t       q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_take,
  output clt_pkg::out_item_t out_item
);

  logic                 idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  clt_pkg::out_item_t   out_r;
  logic                 load;
  logic                 cur_last;
  clt_pkg::lcd_byte_t   cur;

  always_comb begin
    load          = q_valid && (!out_valid_r || out_take);
    cur           = idx_r ? q_head.b1 : q_head.b0;
    cur_last      = !q_head.two || idx_r;
    q_pop         = load && cur_last;
    idx_nxt       = load ? !cur_last : idx_r;
    out_valid_nxt = load || (out_valid_r && !out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= '{is_data: cur.is_data, out_byte: cur.data, last: cur_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> q_valid && q_head.two)
    else $error("second byte pending without a two-byte op");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r && out_r.last)
    else $error("op retired without its last beat");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded beat not presented");

endmodule

@@ sv/char_lcd_cursor_terminal.sv @@
// Character LCD terminal: requests in, HD44780 command/data bytes out.
// A result beat reaches the output ports through the op queue and the output register.
// Throughput: one request per cycle in while the queue is not full, and one beat per
// cycle out while the receiver pops; a request that causes two bytes yields two beats,
// and a four-op queue buffers.
// Reset (synchronous, rst_n low): cursor at 0/0, registers at defaults, queue empty.
module char_lcd_cursor_terminal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  clt_pkg::in_item_t  in_item,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output clt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  logic         accept;
  logic         op_push;
  clt_pkg::op_t op;
  logic         q_valid;
  logic         q_pop;
  clt_pkg::op_t q_head;
  logic         out_valid;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;
  assign out_empty = !out_valid;

  clt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_push   (op_push),
    .op        (op)
  );

  clt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op),
    .full    (in_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  clt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_take  (out_pop),
    .out_item  (out_item)
  );

endmodule

@@ test/clt_scoreboard_pkg.sv @@
// Scoreboard for the character LCD cursor terminal testbench: it tracks the cursor
// and the display registers and predicts the controller bytes for each request.
// Depends on clt_pkg.
package clt_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  class clt_scoreboard;
    logic [5:0] columns;
    logic [2:0] rows;
    logic [6:0] row_base [4];
    logic [3:0] cursor_row;
    logic [6:0] cursor_col;
    clt_pkg::out_item_t expected_beats [$];
    clt_pkg::out_item_t staged [$];
    int         errors;

    function new();
      columns     = clt_pkg::COLS_RESET;
      rows        = clt_pkg::ROWS_RESET;
      row_base[0] = clt_pkg::BASE0_RESET;
      row_base[1] = clt_pkg::BASE1_RESET;
      row_base[2] = clt_pkg::BASE2_RESET;
      row_base[3] = clt_pkg::BASE3_RESET;
      cursor_row  = '0;
      cursor_col  = '0;
      errors      = 0;
    endfunction

    function void apply_config(clt_pkg::cfg_index_t idx, logic [6:0] data);
      case (idx)
        clt_pkg::CFG_COLUMNS: columns = data[5:0];
        clt_pkg::CFG_ROWS:    rows = data[2:0];
        clt_pkg::CFG_BASE0:   row_base[0] = data;
        clt_pkg::CFG_BASE1:   row_base[1] = data;
        clt_pkg::CFG_BASE2:   row_base[2] = data;
        clt_pkg::CFG_BASE3:   row_base[3] = data;
        default: ;
      endcase
    endfunction

    function void stage(logic is_data, logic [7:0] value);
      clt_pkg::out_item_t beat;
      beat.is_data  = is_data;
      beat.out_byte = value;
      beat.last     = 1'b0;
      staged.push_back(beat);
    endfunction

    // The cursor always moves, but rows beyond the configured or physical
    // count get no set-position command.
    function void move_to(int unsigned x, int unsigned y);
      logic [7:0] addr;
      cursor_row = y[3:0];
      cursor_col = x[6:0];
      if (y < rows && y < clt_pkg::MAX_ROWS) begin
        addr = clt_pkg::CMD_SET_ADDR + 8'(row_base[y[1:0]]) + 8'(x[6:0]);
        stage(1'b0, addr);
      end
    endfunction

    function void clear_screen();
      stage(1'b0, clt_pkg::CMD_CLEAR);
      stage(1'b0, clt_pkg::CMD_HOME);
      cursor_row = '0;
      cursor_col = '0;
    endfunction

    function void print_char(logic [7:0] c);
      int unsigned next_row;
      next_row = cursor_row + 1;
      // Codes of 128 and above are negative and fall below the threshold too.
      if (c >= 8'h80 || c < 8'(clt_pkg::CH_MIN)) return;
      if (c == 8'(clt_pkg::CH_CR)) begin
        move_to(0, cursor_row);
      end else if (c == 8'(clt_pkg::CH_LF)) begin
        if (next_row < rows) move_to(0, next_row);
        else clear_screen();
      end else if (cursor_col < columns) begin
        stage(1'b1, c);
        cursor_col = cursor_col + 7'd1;
      end else if (next_row < rows) begin
        move_to(0, next_row);
        stage(1'b1, c);
        cursor_col = 7'd1;
      end else begin
        // Wrapping off the bottom clears the screen and drops the character.
        clear_screen();
      end
    endfunction

    function void note_request(clt_pkg::in_item_t req);
      staged.delete();
      case (req.req_type)
        clt_pkg::REQ_CHAR:  print_char(req.char_code);
        clt_pkg::REQ_SETXY: move_to(req.x_pos, req.y_pos);
        clt_pkg::REQ_CLEAR: clear_screen();
        default: ;
      endcase
      if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
      foreach (staged[i]) expected_beats.push_back(staged[i]);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(clt_pkg::out_item_t got);
      clt_pkg::out_item_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t ns: beat with nothing expected, actual is_data=%0d byte=%02h last=%0d",
                 $time, got.is_data, got.out_byte, got.last);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("is_data", want.is_data, got.is_data);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

@@ test/char_lcd_cursor_terminal_tb.sv @@
// Testbench top for char_lcd_cursor_terminal: directed and random requests under
// several display settings, with bursty input and a stalling receiver.
// Depends on clt_pkg, clt_scoreboard_pkg and the block's RTL.
module char_lcd_cursor_terminal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 9;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEM_W          = $bits(clt_pkg::in_item_t);
  // Request type with no meaning; the block ignores it.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  clt_pkg::in_item_t  in_item = '0;
  logic               in_full;
  logic               out_empty;
  logic               out_pop = 1'b0;
  clt_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [6:0]         cfg_data = '0;

  clt_scoreboard_pkg::clt_scoreboard sb;
  int cur_cols;
  int cur_rows;
  int pop_percent = 100;
  int pop_hold = 0;

  char_lcd_cursor_terminal i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) sb.note_request(in_item);
    if (rst_n && out_pop && !out_empty) sb.check_beat(out_item);
  end

  // The receiver switches between no stalls, light and heavy stalling.
  always @(negedge clk) begin
    if (pop_hold == 0) begin
      case ($urandom_range(0, 2))
        0: pop_percent <= 100;
        1: pop_percent <= 60;
        default: pop_percent <= 25;
      endcase
      pop_hold <= $urandom_range(20, 200);
    end else begin
      pop_hold <= pop_hold - 1;
    end
    out_pop <= ($urandom_range(1, 100) <= pop_percent);
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic clt_pkg::in_item_t char_req(logic [7:0] c);
    clt_pkg::in_item_t req;
    req = '0;
    req.req_type  = clt_pkg::REQ_CHAR;
    req.char_code = c;
    return req;
  endfunction

  function automatic clt_pkg::in_item_t setxy_req(logic [6:0] x, logic [2:0] y);
    clt_pkg::in_item_t req;
    req = '0;
    req.req_type = clt_pkg::REQ_SETXY;
    req.x_pos    = x;
    req.y_pos    = y;
    return req;
  endfunction

  function automatic clt_pkg::in_item_t random_request();
    logic [ITEM_W-1:0] raw;
    clt_pkg::in_item_t req;
    int roll;
    int sub;
    raw  = ITEM_W'($urandom);
    req  = raw;
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (roll < 62) begin
      req.req_type = clt_pkg::REQ_CHAR;
      if (sub < 70) req.char_code = 8'($urandom_range(11, 127));
      else if (sub < 82) req.char_code = 8'(clt_pkg::CH_LF);
      else if (sub < 90) req.char_code = 8'(clt_pkg::CH_CR);
      else req.char_code = 8'($urandom_range(0, 255));
    end else if (roll < 82) begin
      req.req_type = clt_pkg::REQ_SETXY;
      req.x_pos = (sub < 75) ? 7'($urandom_range(0, cur_cols + 1)) : 7'($urandom_range(0, 127));
      req.y_pos = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, cur_rows)) :
                                                3'($urandom_range(0, 7));
    end else if (roll < 90) begin
      req.req_type = clt_pkg::REQ_CLEAR;
    end else if (roll < 94) begin
      req.req_type = REQ_UNKNOWN;
    end
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is accepted.
  task automatic drive_request(clt_pkg::in_item_t req);
    in_push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(clt_pkg::cfg_index_t idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_config(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int cols, int rows, int b0, int b1, int b2, int b3);
    wait_drained();
    write_register(clt_pkg::CFG_COLUMNS, 7'(cols));
    write_register(clt_pkg::CFG_ROWS, 7'(rows));
    write_register(clt_pkg::CFG_BASE0, 7'(b0));
    write_register(clt_pkg::CFG_BASE1, 7'(b1));
    write_register(clt_pkg::CFG_BASE2, 7'(b2));
    write_register(clt_pkg::CFG_BASE3, 7'(b3));
    cfg_valid <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
  endtask

  // Runs under the reset settings: 16 columns, 2 rows.
  task automatic run_directed();
    clt_pkg::in_item_t seq [$];
    clt_pkg::in_item_t req;
    req = '0;
    req.req_type = clt_pkg::REQ_CLEAR;
    seq.push_back(req);
    seq.push_back(char_req(8'd65));
    seq.push_back(char_req(8'd127));
    seq.push_back(char_req(8'h80));
    seq.push_back(char_req(8'hFF));
    seq.push_back(char_req(8'd9));
    seq.push_back(char_req(8'd0));
    seq.push_back(char_req(8'(clt_pkg::CH_LF)));
    seq.push_back(char_req(8'(clt_pkg::CH_LF)));
    seq.push_back(char_req(8'(clt_pkg::CH_CR)));
    // A column past the edge on a row past the count, then a printable one.
    seq.push_back(setxy_req(7'd127, 3'd7));
    seq.push_back(char_req(8'd66));
    seq.push_back(setxy_req(7'd15, 3'd1));
    seq.push_back(char_req(8'd67));
    seq.push_back(char_req(8'd68));
    seq.push_back(setxy_req(7'd15, 3'd0));
    seq.push_back(char_req(8'd69));
    seq.push_back(char_req(8'd70));
    req.req_type = REQ_UNKNOWN;
    seq.push_back(req);
    seq.push_back(setxy_req(7'd0, 3'd3));
    seq.push_back(char_req(8'(clt_pkg::CH_CR)));
    seq.push_back(char_req(8'd11));
    seq.push_back(char_req(8'd12));
    seq.push_back(char_req(8'd14));
    foreach (seq[i]) drive_request(seq[i]);
    in_push <= 1'b0;
  endtask

  task automatic run_random(int target);
    clt_pkg::in_item_t req;
    int done;
    int burst;
    int gap;
    done = 0;
    while (done < target) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst; b++) begin
        req = random_request();
        drive_request(req);
        done++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_push <= 1'b0;
  endtask

  initial begin
    sb = new();
    cur_cols = clt_pkg::COLS_RESET;
    cur_rows = clt_pkg::ROWS_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(16, 2, 0, 64, 16, 80);
        1: configure(1, 1, 0, 0, 0, 0);
        2: configure(40, 4, 0, 64, 20, 84);
        3: configure(0, 0, 127, 127, 127, 127);
        4: configure(63, 7, 127, 0, 127, 0);
        5: configure(20, 4, 0, 64, 20, 84);
        default: begin
          configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 40),
                    $urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom_range(0, 127));
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
